@@ rtl/rsu_pkg.sv @@
// Shared types and constants of the Rprop step adaptation block.
package rsu_pkg;

  localparam int unsigned FactorW   = 16;
  localparam int unsigned StepW     = 32;
  localparam int unsigned MagW      = 31;
  localparam int unsigned ProdW     = 48;
  localparam int unsigned FracShift = 12;
  localparam int unsigned CfgIdxW   = 3;

  // Output queue; it also bounds the transactions in flight.
  localparam int unsigned OutFifoDepth = 8;
  localparam int unsigned OutFifoAw    = 3;

  localparam logic [ProdW:0] RoundBias = (ProdW + 1)'(1) << (FracShift - 1);

  localparam logic [FactorW-1:0] GrowFactorRst   = 16'd4915;
  localparam logic [FactorW-1:0] ShrinkFactorRst = 16'd2048;
  localparam logic [MagW-1:0]    StepMinRst      = 31'd17;
  localparam logic [MagW-1:0]    StepMaxRst      = 31'd838860800;
  localparam logic [MagW-1:0]    StepStartRst    = 31'd1677722;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGrowFactor   = 3'd0,
    CfgShrinkFactor = 3'd1,
    CfgStepMin      = 3'd2,
    CfgStepMax      = 3'd3,
    CfgStepStart    = 3'd4
  } cfg_reg_e;

  // Control that travels with each item down the pipeline.
  typedef struct packed {
    logic valid;
    logic ok;
    logic zero_grad;
    logic grad_neg;
  } stage_ctl_t;

endpackage

@@ rtl/rsu_ram.sv @@
// Generic single write port RAM with one registered read port.
module rsu_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 8192,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rsu_step_pipe.sv @@
// Step arithmetic: magnitude and factor select, scale, round, clamp and sign.
module rsu_step_pipe import rsu_pkg::*; #(
  parameter int unsigned AW = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stage_ctl_t         in_ctl_i,
  input  logic [AW-1:0]      in_addr_i,
  input  logic [StepW-1:0]   old_step_i,
  input  logic [FactorW-1:0] grow_factor_i,
  input  logic [FactorW-1:0] shrink_factor_i,
  input  logic [MagW-1:0]    step_min_i,
  input  logic [MagW-1:0]    step_max_i,
  output stage_ctl_t         b_ctl_o,
  output logic [AW-1:0]      b_addr_o,
  output logic               wr_en_o,
  output logic [AW-1:0]      wr_addr_o,
  output logic [StepW-1:0]   wr_step_o,
  output stage_ctl_t         res_ctl_o,
  output logic [AW-1:0]      res_addr_o,
  output logic [StepW-1:0]   res_step_o
);

  stage_ctl_t         b_ctl_q, c_ctl_q, d_ctl_q;
  logic [AW-1:0]      b_addr_q, c_addr_q, d_addr_q;
  logic [StepW-1:0]   b_mag_q;
  logic [FactorW-1:0] b_factor_q;
  logic [ProdW-1:0]   c_prod_q;
  logic [StepW-1:0]   d_step_q;

  logic               old_neg;
  logic [StepW-1:0]   mag_d;
  logic [FactorW-1:0] factor_d;
  logic [ProdW:0]     rounded;
  logic [ProdW-FracShift:0] scaled;
  logic [MagW-1:0]    mag_hi;
  logic [MagW-1:0]    mag_clamped;
  logic [StepW-1:0]   new_step;

  // Magnitude of the old step and the factor that applies to it.
  always_comb begin
    old_neg  = old_step_i[StepW-1];
    mag_d    = old_neg ? (~old_step_i + StepW'(1)) : old_step_i;
    factor_d = (old_neg != in_ctl_i.grad_neg) ? grow_factor_i : shrink_factor_i;
  end

  // Round to nearest, clamp to [min, max], then point against the gradient; a zero gradient gives zero.
  always_comb begin
    rounded     = {1'b0, c_prod_q} + RoundBias;
    scaled      = rounded[ProdW:FracShift];
    mag_hi      = (scaled > (ProdW - FracShift + 1)'(step_max_i)) ? step_max_i
                                                                  : scaled[MagW-1:0];
    mag_clamped = (mag_hi < step_min_i) ? step_min_i : mag_hi;
    if (c_ctl_q.zero_grad) begin
      new_step = '0;
    end else if (c_ctl_q.grad_neg) begin
      new_step = {1'b0, mag_clamped};
    end else begin
      new_step = ~{1'b0, mag_clamped} + StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_ctl_q <= '0;
      c_ctl_q <= '0;
      d_ctl_q <= '0;
    end else begin
      b_ctl_q <= in_ctl_i;
      c_ctl_q <= b_ctl_q;
      d_ctl_q <= c_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_addr_q   <= in_addr_i;
    b_mag_q    <= mag_d;
    b_factor_q <= factor_d;
    c_addr_q   <= b_addr_q;
    c_prod_q   <= ProdW'(b_mag_q) * ProdW'(b_factor_q);
    d_addr_q   <= c_addr_q;
    d_step_q   <= new_step;
  end

  assign b_ctl_o    = b_ctl_q;
  assign b_addr_o   = b_addr_q;
  assign wr_en_o    = c_ctl_q.valid & c_ctl_q.ok;
  assign wr_addr_o  = c_addr_q;
  assign wr_step_o  = new_step;
  assign res_ctl_o  = d_ctl_q;
  assign res_addr_o = d_addr_q;
  assign res_step_o = d_step_q;

endmodule

@@ rtl/rsu_out_fifo.sv @@
// Output queue of finished steps toward the result channel.
module rsu_out_fifo import rsu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [StepW-1:0] push_data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [StepW-1:0] data_o
);

  logic [StepW-1:0]     mem_q [OutFifoDepth];
  logic [OutFifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [OutFifoAw:0]   count_q;
  logic                 pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o & ~stall_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OutFifoAw'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OutFifoAw'(1);
      end
      count_q <= count_q + (OutFifoAw + 1)'(push_i) - (OutFifoAw + 1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/rprop_step_update_top.sv @@
// Top level of the Rprop step adaptation block.
//
// Keeps one signed Q8.24 step per weight, addressed by layer and entry, and
// adapts it by the sign of each incoming gradient. Input channel: in_valid_i,
// in_stall_o and the fields layer, entry and grad_sign; one transaction per
// gradient. Result channel: out_valid_o, out_stall_i and out_step_o, one
// transaction per input, in input order.
// Throughput is one transaction per cycle while in_stall_o is low. A transaction
// whose in-range address equals that of a valid in-range transaction in
// stage A or B waits until the earlier one reaches the store write stage.
// On its way to the result handshake a transaction passes store read,
// factor select, multiply, round/clamp/write and the output queue.
// Up to eight transactions may be in flight; when the receiver stalls the
// queue absorbs them, after that in_stall_o rises and nothing is lost.
// After reset the store is swept once to clear its touched marks, one word
// a cycle, LAYERS * ENTRIES_PER_LAYER words (8192 by default); in_stall_o
// stays high during the sweep, configuration writes are taken as usual.
// Configuration registers reset to their default values. The user must write
// them only while the block is idle; the block itself does not enforce this.
module rprop_step_update_top import rsu_pkg::*; #(
  parameter int unsigned LAYERS            = 8,
  parameter int unsigned ENTRIES_PER_LAYER = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         in_layer_i,
  input  logic [9:0]         in_entry_i,
  input  logic signed [1:0]  in_grad_sign_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_step_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [MagW-1:0]    cfg_wdata_i
);

  localparam int unsigned Depth = LAYERS * ENTRIES_PER_LAYER;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RamW  = StepW + 1;

  // Configuration registers.
  logic [FactorW-1:0] grow_factor_q, shrink_factor_q;
  logic [MagW-1:0]    step_min_q, step_max_q, step_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grow_factor_q   <= GrowFactorRst;
      shrink_factor_q <= ShrinkFactorRst;
      step_min_q      <= StepMinRst;
      step_max_q      <= StepMaxRst;
      step_start_q    <= StepStartRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgGrowFactor:   grow_factor_q   <= cfg_wdata_i[FactorW-1:0];
        CfgShrinkFactor: shrink_factor_q <= cfg_wdata_i[FactorW-1:0];
        CfgStepMin:      step_min_q      <= cfg_wdata_i;
        CfgStepMax:      step_max_q      <= cfg_wdata_i;
        CfgStepStart:    step_start_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clearing sweep: write every store word with its touched mark low.
  logic          clr_active_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(Depth - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // Decode the incoming address; out-of-range items bypass the store.
  logic          in_ok;
  logic [AW-1:0] in_addr;

  assign in_ok   = (int'(in_layer_i) < LAYERS) && (int'(in_entry_i) < ENTRIES_PER_LAYER);
  assign in_addr = AW'(in_layer_i) * AW'(ENTRIES_PER_LAYER) + AW'(in_entry_i);

  // Stage A: store read in flight.
  stage_ctl_t    a_ctl_q;
  logic [AW-1:0] a_addr_q;

  // Pipeline stages owned by the arithmetic unit.
  stage_ctl_t       b_ctl, res_ctl;
  logic [AW-1:0]    b_addr, wr_addr, res_addr;
  logic             wr_en;
  logic [StepW-1:0] wr_step, res_step;

  // Interlock: the two younger in-range items have not written yet.
  logic hit_a, hit_b, hazard;
  logic [OutFifoAw:0] inflight_q;
  logic in_accept, out_pop;

  assign hit_a  = a_ctl_q.valid & a_ctl_q.ok & (a_addr_q == in_addr);
  assign hit_b  = b_ctl.valid & b_ctl.ok & (b_addr == in_addr);
  assign hazard = in_ok & (hit_a | hit_b);

  assign in_stall_o = clr_active_q | hazard
                    | (inflight_q >= (OutFifoAw + 1)'(OutFifoDepth));
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign out_pop    = out_valid_o & ~out_stall_i;

  // Count transactions between acceptance and delivery.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + (OutFifoAw + 1)'(in_accept) - (OutFifoAw + 1)'(out_pop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q <= '0;
    end else begin
      a_ctl_q.valid     <= in_accept;
      a_ctl_q.ok        <= in_ok;
      a_ctl_q.zero_grad <= (in_grad_sign_i == 2'sd0);
      a_ctl_q.grad_neg  <= in_grad_sign_i[1];
    end
  end

  always_ff @(posedge clk_i) begin
    a_addr_q <= in_addr;
  end

  // Step store: touched mark on top of the step word.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [RamW-1:0] ram_wdata, ram_rdata;

  assign ram_we    = clr_active_q | wr_en;
  assign ram_waddr = clr_active_q ? clr_addr_q : wr_addr;
  assign ram_wdata = clr_active_q ? '0 : {1'b1, wr_step};

  rsu_ram #(
    .WIDTH (RamW),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // The item in the result stage was written on the same edge as the read
  // for stage A, so take its step directly on an address match.
  logic             fwd_hit;
  logic [StepW-1:0] old_step;

  assign fwd_hit = res_ctl.valid & res_ctl.ok & (res_addr == a_addr_q);

  always_comb begin
    if (!a_ctl_q.ok) begin
      old_step = {1'b0, step_start_q};
    end else if (fwd_hit) begin
      old_step = res_step;
    end else if (ram_rdata[StepW]) begin
      old_step = ram_rdata[StepW-1:0];
    end else begin
      old_step = {1'b0, step_start_q};
    end
  end

  rsu_step_pipe #(
    .AW (AW)
  ) u_step_pipe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_ctl_i        (a_ctl_q),
    .in_addr_i       (a_addr_q),
    .old_step_i      (old_step),
    .grow_factor_i   (grow_factor_q),
    .shrink_factor_i (shrink_factor_q),
    .step_min_i      (step_min_q),
    .step_max_i      (step_max_q),
    .b_ctl_o         (b_ctl),
    .b_addr_o        (b_addr),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_step_o       (wr_step),
    .res_ctl_o       (res_ctl),
    .res_addr_o      (res_addr),
    .res_step_o      (res_step)
  );

  logic [StepW-1:0] fifo_data;

  rsu_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_ctl.valid),
    .push_data_i (res_step),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .data_o      (fifo_data)
  );

  assign out_step_o = fifo_data;

  // The credit count bounds the queue, so it can never overflow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= (OutFifoAw + 1)'(OutFifoDepth))
    else $error("in-flight count exceeds output queue depth");

  // Nothing enters while the store is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !in_accept)
    else $error("transaction accepted during clearing sweep");

  // A result can only be offered for a transaction that was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inflight_q != '0))
    else $error("result offered with nothing in flight");

  // Back-to-back transactions to one stored word must be held apart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_ok) |=> !(in_accept && in_ok && (in_addr == $past(in_addr))))
    else $error("read-modify-write interlock missed a repeated address");

endmodule

@@ bench/rprop_step_update_top_tb.sv @@
// Self-checking testbench for the Rprop step adaptation block.
`timescale 1ns / 100ps

module rprop_step_update_top_tb import rsu_pkg::*; ();

  localparam int unsigned Layers     = 8;
  localparam int unsigned Entries    = 1024;
  localparam int unsigned StoreDepth = Layers * Entries;
  // The limit leaves a wide margin over the post-reset sweep of all StoreDepth words.
  localparam int unsigned CycleLimit = 250000;
  localparam int unsigned DrainWait  = 20;
  localparam int unsigned MaxPrinted = 50;

  // Gradient sign encodings on the two-bit signed field.
  localparam logic signed [1:0] GradZero   = 2'sb00;
  localparam logic signed [1:0] GradPos    = 2'sb01;
  localparam logic signed [1:0] GradNegAlt = 2'sb10;  // minus two, taken as negative
  localparam logic signed [1:0] GradNeg    = 2'sb11;

  localparam logic [MagW-1:0] MagTop = {MagW{1'b1}};

  typedef struct {
    logic [2:0]        layer;
    logic [9:0]        entry;
    logic signed [1:0] grad_sign;
  } grad_item_t;

  // Clock, reset and every block input start at known values.
  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic [2:0]         in_layer_i     = '0;
  logic [9:0]         in_entry_i     = '0;
  logic signed [1:0]  in_grad_sign_i = '0;
  logic               out_stall_i    = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i      = '0;
  logic [MagW-1:0]    cfg_wdata_i    = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic signed [31:0] out_step_o;

  rprop_step_update_top #(
    .LAYERS           (Layers),
    .ENTRIES_PER_LAYER(Entries)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_layer_i    (in_layer_i),
    .in_entry_i    (in_entry_i),
    .in_grad_sign_i(in_grad_sign_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_step_o    (out_step_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the step store, its touched marks and the registers.
  logic [31:0]        step_mem    [StoreDepth];
  bit                 touched_mem [StoreDepth];
  logic [FactorW-1:0] grow_factor   = GrowFactorRst;
  logic [FactorW-1:0] shrink_factor = ShrinkFactorRst;
  logic [MagW-1:0]    step_min      = StepMinRst;
  logic [MagW-1:0]    step_max      = StepMaxRst;
  logic [MagW-1:0]    step_start    = StepStartRst;

  grad_item_t  grad_q[$];      // gradients waiting to be driven
  logic [31:0] step_exp_q[$];  // predicted steps, oldest first

  bit          idle_on;        // random idling on both channels
  bit          in_taken;       // input transaction at the last rising edge
  int unsigned in_gap;
  int unsigned out_hold;
  int unsigned cycles;
  int unsigned errors;
  int unsigned n_grads;
  int unsigned n_steps;
  int unsigned n_settings;
  logic [12:0] hot_addr [16];
  logic [12:0] last_addr = '0;

  // Adapt the stored step of one weight to a gradient sign; update the
  // shadow store and return the new step.
  function automatic logic [31:0] apply_gradient(grad_item_t it);
    logic        in_range;
    logic [12:0] addr;
    logic [31:0] prev;
    logic [31:0] next;
    logic        g_neg;
    logic        p_neg;
    logic [63:0] mag;
    in_range = (it.layer < Layers) && (it.entry < Entries);
    addr     = {it.layer, it.entry};
    prev     = (in_range && touched_mem[addr]) ? step_mem[addr] : {1'b0, step_start};
    if (it.grad_sign == GradZero) begin
      next = '0;
    end else begin
      g_neg = it.grad_sign[1];
      p_neg = prev[31];
      mag   = {32'd0, p_neg ? (~prev + 32'd1) : prev};
      // A zero step stays unscaled; opposite signs mean keep going downhill.
      if (prev != '0) begin
        mag = (mag * 64'(p_neg != g_neg ? grow_factor : shrink_factor) + 64'd2048) >> 12;
      end
      // Upper bound first, so a minimum above the maximum wins.
      if (mag > 64'(step_max)) mag = 64'(step_max);
      if (mag < 64'(step_min)) mag = 64'(step_min);
      next = mag[31:0];
      if (!g_neg) next = ~next + 32'd1;
    end
    if (in_range) begin
      step_mem[addr]    = next;
      touched_mem[addr] = 1'b1;
    end
    return next;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < MaxPrinted) begin
      $display("%0t: %s: got %h, want %h", $time, what, got, want);
    end
    errors++;
  endtask

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("rprop_step_update_top_tb failed");
      $finish;
    end
  end

  // Monitor: track register writes, predict each accepted gradient and
  // check each accepted result against the oldest prediction.
  always @(posedge clk_i) begin : monitor
    logic [31:0] want;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgGrowFactor:   grow_factor   = cfg_wdata_i[FactorW-1:0];
          CfgShrinkFactor: shrink_factor = cfg_wdata_i[FactorW-1:0];
          CfgStepMin:      step_min      = cfg_wdata_i;
          CfgStepMax:      step_max      = cfg_wdata_i;
          CfgStepStart:    step_start    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        step_exp_q.push_back(apply_gradient('{in_layer_i, in_entry_i, in_grad_sign_i}));
        in_taken = 1'b1;
        n_grads++;
      end
      if (out_valid_o && !out_stall_i) begin
        n_steps++;
        if (step_exp_q.size() == 0) begin
          report_mismatch("step with no transaction pending", out_step_o, 'x);
        end else begin
          want = step_exp_q.pop_front();
          if (out_step_o !== want) report_mismatch("step mismatch", out_step_o, want);
        end
      end
    end
  end

  // Driver: hold a stalled transaction, otherwise advance to the next
  // gradient after an optional gap.
  always @(negedge clk_i) begin : driver
    grad_item_t it;
    if (!in_valid_i || in_taken) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (grad_q.size() > 0) begin
        it             = grad_q.pop_front();
        in_layer_i     <= it.layer;
        in_entry_i     <= it.entry;
        in_grad_sign_i <= it.grad_sign;
        in_valid_i     <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 4);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: now and then stall in bursts of random length.
  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_stall_i <= 1'b1;
      out_hold    <= out_hold - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      out_hold    <= $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic push_grad(logic [2:0] layer, logic [9:0] entry, logic signed [1:0] gs);
    grad_q.push_back('{layer, entry, gs});
  endtask

  // Mostly revisit a small set of weights so steps evolve over many
  // updates; repeat the last weight for back-to-back hazards; else roam.
  task automatic push_random(int unsigned n);
    int unsigned pick;
    logic [12:0] a;
    logic signed [1:0] gs;
    for (int k = 0; k < 16; k++) hot_addr[k] = 13'($urandom);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) a = last_addr;
      else if (pick < 75) a = hot_addr[$urandom_range(0, 15)];
      else a = 13'($urandom);
      last_addr = a;
      pick = $urandom_range(0, 99);
      if (pick < 40) gs = GradNeg;
      else if (pick < 80) gs = GradPos;
      else if (pick < 88) gs = GradZero;
      else gs = GradNegAlt;
      push_grad(a[12:10], a[9:0], gs);
    end
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [MagW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Idle means nothing queued, nothing driven and no result outstanding.
  task automatic wait_idle();
    while (grad_q.size() != 0 || in_valid_i || step_exp_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic run_phase(logic [FactorW-1:0] grow, logic [FactorW-1:0] shrink,
                           logic [MagW-1:0] lo, logic [MagW-1:0] hi,
                           logic [MagW-1:0] start, int unsigned n, bit idle);
    wait_idle();
    write_cfg(CfgGrowFactor, MagW'(grow));
    write_cfg(CfgShrinkFactor, MagW'(shrink));
    write_cfg(CfgStepMin, lo);
    write_cfg(CfgStepMax, hi);
    write_cfg(CfgStepStart, start);
    n_settings++;
    idle_on = idle;
    push_random(n);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: walk one weight through shrink, grow, zero, lift to
    // minimum and the minus-two sign, then the address extremes.
    idle_on = 1'b1;
    n_settings = 1;
    push_grad(3'd0, 10'd0, GradPos);
    push_grad(3'd0, 10'd0, GradNeg);
    push_grad(3'd0, 10'd0, GradNeg);
    push_grad(3'd0, 10'd0, GradZero);
    push_grad(3'd0, 10'd0, GradPos);
    push_grad(3'd0, 10'd0, GradNegAlt);
    push_grad(3'd0, 10'd0, GradPos);
    push_grad(3'd7, 10'd1023, GradNegAlt);
    push_grad(3'd7, 10'd1023, GradPos);
    push_grad(3'd7, 10'd1023, GradPos);
    push_grad(3'd5, 10'd682, GradNeg);
    push_grad(3'd2, 10'd341, GradPos);
    push_grad(3'd5, 10'd682, GradNeg);
    push_grad(3'd2, 10'd341, GradPos);
    push_grad(3'd0, 10'd0, GradNeg);
    push_grad(3'd3, 10'd512, GradZero);
    push_grad(3'd4, 10'd1, GradNeg);
    push_grad(3'd6, 10'd1022, GradPos);
    push_grad(3'd6, 10'd1022, GradNegAlt);
    push_grad(3'd1, 10'd0, GradNeg);
    push_random(220);

    // Largest growth, shrink to zero, widest clamp, largest start.
    run_phase(16'hFFFF, 16'h0000, '0, MagTop, MagTop, 180, 1'b0);
    // Minimum above maximum: every nonzero gradient lands on the minimum.
    run_phase(16'd4096, 16'd4096, 31'd1000000, 31'd500, 31'd12345, 140, 1'b1);
    // No growth, largest shrink factor, clamp pinned at the top, zero start.
    run_phase(16'h0000, 16'hFFFF, MagTop, MagTop, '0, 140, 1'b1);
    // Everything zero.
    run_phase('0, '0, '0, '0, '0, 80, 1'b1);
    // Plausible training settings; writes to unused indexes change nothing.
    run_phase(16'($urandom_range(4096, 8192)), 16'($urandom_range(1024, 4095)),
              31'($urandom_range(0, 1 << 12)), 31'($urandom_range(1 << 26, 32'h7FFFFFFF)),
              31'($urandom_range(1 << 20, 1 << 26)), 220, 1'b1);
    wait_idle();
    for (int k = int'(CfgStepStart) + 1; k < (1 << CfgIdxW); k++) begin
      write_cfg(CfgIdxW'(k), MagW'($urandom));
    end
    // Fully random registers.
    run_phase(16'($urandom), 16'($urandom), MagW'($urandom), MagW'($urandom),
              MagW'($urandom), 160, 1'b1);
    // Back to reset values, full rate on both sides.
    run_phase(GrowFactorRst, ShrinkFactorRst, StepMinRst, StepMaxRst, StepStartRst,
              250, 1'b0);

    wait_idle();
    repeat (DrainWait) @(negedge clk_i);
    $display("Covered %0d gradient transactions and %0d step results over %0d settings",
             n_grads, n_steps, n_settings);
    $display("including clamp extremes, minimum above maximum and back-to-back updates.");
    if (errors == 0) begin
      $display("rprop_step_update_top_tb passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("rprop_step_update_top_tb failed");
    end
    $finish;
  end

endmodule
